[src/pbw_pkg.sv]
package pbw_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       opaque;
    } pixel_t;

    typedef struct packed {
        logic [7:0] blackness_value;
        logic [7:0] white_level;
    } result_t;

    localparam logic [1:0] MODE_GRAY         = 2'd0;
    localparam logic [1:0] MODE_DARK_NEUTRAL = 2'd1;
    localparam logic [1:0] MODE_MAX_CHANNEL  = 2'd2;

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [1:0] MODE_RESET      = MODE_GRAY;
    localparam logic [7:0] THRESHOLD_RESET = 8'd128;

    localparam int PADDR_W = 3;

    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    localparam logic [9:0] SUM_FULL  = 10'd765;
    localparam logic [7:0] CHAN_FULL = 8'd255;

    // ceil(2^28 / 765), exact floor division for products below 2^18
    localparam logic [18:0] DARK_RECIP = 19'd350897;
    localparam int          DARK_SHIFT = 28;

    localparam int QUOT_W             = 8;
    localparam int REM_W              = 16;
    localparam int DIV_BITS_PER_STAGE = 2;

    typedef struct packed {
        logic [7:0]        blackness;
        logic [7:0]        threshold;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
        logic              zero;
    } div_item_t;

endpackage

[src/pbw_div.sv]
module pbw_div #(
    parameter int BITS_PER_STAGE = pbw_pkg::DIV_BITS_PER_STAGE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pbw_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pbw_pkg::div_item_t  out_item
);
    import pbw_pkg::*;

    localparam int NUM_STAGES = QUOT_W / BITS_PER_STAGE;

    div_item_t               stage_reg  [NUM_STAGES];
    div_item_t               stage_next [NUM_STAGES];
    div_item_t               stage_in   [NUM_STAGES];
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES-1:0]   valid_in;
    logic [NUM_STAGES:0]     en;

    always_comb
    begin
        en[NUM_STAGES] = out_ready;
        for (int s = NUM_STAGES - 1; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign stage_in[s] = in_item;
            assign valid_in[s] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[s] = stage_reg[s-1];
            assign valid_in[s] = valid_reg[s-1];
        end

        // restoring steps, quotient bits msb first
        always_comb
        begin
            div_item_t        item;
            logic [REM_W-1:0] d;
            logic             ge;
            int               b;
            item = stage_in[s];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                b  = QUOT_W - 1 - (s * BITS_PER_STAGE + j);
                d  = {{(REM_W-QUOT_W){1'b0}}, item.threshold} << b;
                ge = item.rem >= d;
                if (ge)
                begin
                    item.rem = item.rem - d;
                end
                item.quot = {item.quot[QUOT_W-2:0], ge};
            end
            stage_next[s] = item;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                valid_reg[s] <= valid_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_item  = stage_reg[NUM_STAGES-1];

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.zero) |-> (out_item.rem < {8'b0, out_item.threshold}))
        else $error("remainder not below threshold");

    a_reconstruct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.zero) |->
        (({9'b0, out_item.quot} * {9'b0, out_item.threshold} + {1'b0, out_item.rem}) ==
         ({9'b0, out_item.threshold - out_item.blackness} * {9'b0, CHAN_FULL})))
        else $error("quotient and remainder do not rebuild the dividend");

    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !en[1]) |=> (valid_reg[0] && $stable(stage_reg[0])))
        else $error("stalled divider stage changed");

endmodule

[src/pixel_blackness_white_ink.sv]
// Per-pixel blackness and white-ink level. One pixel item is taken per clock
// while pixel_ready is high, and one result item comes out per pixel, in order.
// The path runs through four front stages (min/max and luma products, dark product,
// reciprocal multiply for the /765, mode select and dividend) followed by the
// pipelined restoring divider that forms (threshold - blackness) * 255 / threshold.
// Every stage holds its item under backpressure, so stalls on the result side lose
// nothing. Mode and threshold are taken through the APB port at byte addresses 0
// and 4; mode 3 gives blackness 0.
module pixel_blackness_white_ink #(
    parameter int DIV_BITS_PER_STAGE = pbw_pkg::DIV_BITS_PER_STAGE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  pbw_pkg::pixel_t             pixel,
    output logic                        result_valid,
    input  logic                        result_ready,
    output pbw_pkg::result_t            result
);
    import pbw_pkg::*;

    logic [1:0] mode_reg;
    logic [7:0] threshold_reg;
    logic       cfg_write;
    logic       reg_sel;

    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[PADDR_W-1];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_MODE)
            begin
                mode_reg <= pwdata[1:0];
            end
            else
            begin
                threshold_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE:      prdata = {30'b0, mode_reg};
            REG_THRESHOLD: prdata = {24'b0, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    // stall chain
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic div_ready;

    assign en4         = !v4_reg || div_ready;
    assign en3         = !v3_reg || en4;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign pixel_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pixel_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: extremes, channel sum, luma products
    logic [1:0]  mode1_reg;
    logic [7:0]  thr1_reg;
    logic        opaque1_reg;
    logic [7:0]  hi1_reg, lo1_reg;
    logic [9:0]  sum1_reg;
    logic [23:0] pr1_reg, pg1_reg, pb1_reg;
    logic [7:0]  hi_next, lo_next;
    logic [7:0]  rg_hi, rg_lo;

    always_comb
    begin
        rg_hi   = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        rg_lo   = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        hi_next = (rg_hi > pixel.blue) ? rg_hi : pixel.blue;
        lo_next = (rg_lo < pixel.blue) ? rg_lo : pixel.blue;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg   <= mode_reg;
            thr1_reg    <= threshold_reg;
            opaque1_reg <= pixel.opaque;
            hi1_reg     <= hi_next;
            lo1_reg     <= lo_next;
            sum1_reg    <= {2'b0, pixel.red} + {2'b0, pixel.green} + {2'b0, pixel.blue};
            pr1_reg     <= {16'b0, pixel.red} * {8'b0, LUMA_WR};
            pg1_reg     <= {16'b0, pixel.green} * {8'b0, LUMA_WG};
            pb1_reg     <= {16'b0, pixel.blue} * {8'b0, LUMA_WB};
        end
    end

    // stage 2: luma, dark-neutral product, inverse max
    logic [1:0]  mode2_reg;
    logic [7:0]  thr2_reg;
    logic        opaque2_reg;
    logic [7:0]  luma2_reg;
    logic [17:0] dark2_reg;
    logic [7:0]  maxinv2_reg;
    logic [23:0] luma_next;
    logic [9:0]  dark_a;
    logic [7:0]  dark_b;

    always_comb
    begin
        luma_next = pr1_reg + pg1_reg + pb1_reg;
        dark_a    = SUM_FULL - sum1_reg;
        dark_b    = CHAN_FULL - (hi1_reg - lo1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mode2_reg   <= mode1_reg;
            thr2_reg    <= thr1_reg;
            opaque2_reg <= opaque1_reg;
            luma2_reg   <= luma_next[23:16];
            dark2_reg   <= {8'b0, dark_a} * {10'b0, dark_b};
            maxinv2_reg <= CHAN_FULL - hi1_reg;
        end
    end

    // stage 3: divide by 765 through the reciprocal
    logic [1:0]  mode3_reg;
    logic [7:0]  thr3_reg;
    logic        opaque3_reg;
    logic [7:0]  luma3_reg;
    logic [7:0]  darkq3_reg;
    logic [7:0]  maxinv3_reg;
    logic [36:0] dark_prod;

    assign dark_prod = {19'b0, dark2_reg} * {18'b0, DARK_RECIP};

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            mode3_reg   <= mode2_reg;
            thr3_reg    <= thr2_reg;
            opaque3_reg <= opaque2_reg;
            luma3_reg   <= luma2_reg;
            darkq3_reg  <= dark_prod[DARK_SHIFT+7:DARK_SHIFT];
            maxinv3_reg <= maxinv2_reg;
        end
    end

    // stage 4: mode select, dividend for the white level
    div_item_t  div_in_reg;
    div_item_t  div_in_next;
    div_item_t  div_out;
    logic [7:0] blk_sel;
    logic [7:0] diff;

    always_comb
    begin
        case (mode3_reg)
            MODE_GRAY:         blk_sel = luma3_reg;
            MODE_DARK_NEUTRAL: blk_sel = darkq3_reg;
            MODE_MAX_CHANNEL:  blk_sel = maxinv3_reg;
            default:           blk_sel = 8'd0;
        endcase
        diff                  = thr3_reg - blk_sel;
        div_in_next.blackness = blk_sel;
        div_in_next.threshold = thr3_reg;
        div_in_next.zero      = !opaque3_reg || (blk_sel >= thr3_reg);
        div_in_next.quot      = '0;
        div_in_next.rem       = div_in_next.zero ? '0 : ({diff, 8'b0} - {8'b0, diff});
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            div_in_reg <= div_in_next;
        end
    end

    pbw_div #(
        .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (div_ready),
        .in_item   (div_in_reg),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (div_out)
    );

    assign result.blackness_value = div_out.blackness;
    assign result.white_level     = div_out.zero ? 8'd0 : div_out.quot;

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(hi1_reg) && $stable(sum1_reg)))
        else $error("stalled front stage changed");

    a_max_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en4 && (mode3_reg == MODE_MAX_CHANNEL)) |=>
        (div_in_reg.blackness == $past(maxinv3_reg)))
        else $error("max-channel blackness not selected");

endmodule

[verif/pixel_blackness_white_ink_scoreboard.sv]
module pixel_blackness_white_ink_scoreboard (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        pixel_valid,
    input  logic                        pixel_ready,
    input  pbw_pkg::pixel_t             pixel,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  pbw_pkg::result_t            result,
    output int                          errors,
    output int                          pending
);
    import pbw_pkg::*;

    logic [1:0] ink_mode;
    logic [7:0] ink_threshold;
    result_t    expected_ink[$];
    result_t    want;
    int         err_count;

    function automatic result_t predict_ink(pixel_t p, logic [1:0] sel_mode, logic [7:0] thr);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned hi;
        int unsigned lo;
        int unsigned blk;
        int unsigned t;
        int unsigned white;
        result_t     res;
        r = p.red;
        g = p.green;
        b = p.blue;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        case (sel_mode)
            MODE_GRAY:
            begin
                blk = (LUMA_WR * r + LUMA_WG * g + LUMA_WB * b) >> 16;
            end
            MODE_DARK_NEUTRAL:
            begin
                blk = ((SUM_FULL - (r + g + b)) * (CHAN_FULL - (hi - lo))) / SUM_FULL;
            end
            MODE_MAX_CHANNEL:
            begin
                blk = CHAN_FULL - hi;
            end
            default:
            begin
                blk = 0;
            end
        endcase
        blk = blk & 32'hFF;
        t = thr;
        // zero threshold never divides since every blackness is at or above it
        if (!p.opaque || blk >= t)
        begin
            white = 0;
        end
        else
        begin
            white = ((t - blk) * CHAN_FULL) / t;
        end
        res.blackness_value = blk[7:0];
        res.white_level     = white[7:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink_mode      <= MODE_RESET;
            ink_threshold <= THRESHOLD_RESET;
            expected_ink.delete();
            err_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1] == REG_MODE)
                begin
                    ink_mode <= pwdata[1:0];
                end
                else
                begin
                    ink_threshold <= pwdata[7:0];
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                expected_ink.insert(expected_ink.size(),
                                    predict_ink(pixel, ink_mode, ink_threshold));
            end
            if (result_valid && result_ready)
            begin
                if (expected_ink.size() == 0)
                begin
                    $display("%0t: result item with none expected: blackness %0d white %0d",
                             $time, result.blackness_value, result.white_level);
                    err_count++;
                end
                else
                begin
                    want = expected_ink.pop_front();
                    if (result.blackness_value !== want.blackness_value)
                    begin
                        $display("%0t: blackness_value expected %0d actual %0d",
                                 $time, want.blackness_value, result.blackness_value);
                        err_count++;
                    end
                    if (result.white_level !== want.white_level)
                    begin
                        $display("%0t: white_level expected %0d actual %0d",
                                 $time, want.white_level, result.white_level);
                        err_count++;
                    end
                end
            end
            pending <= expected_ink.size();
            errors  <= err_count;
        end
    end

endmodule

[verif/pixel_blackness_white_ink_tb.sv]
module pixel_blackness_white_ink_tb;
    import pbw_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int GAP_MAX      = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 100;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               pixel_valid;
    logic               pixel_ready;
    pixel_t             pixel;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 no_idle;

    pixel_blackness_white_ink dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    pixel_blackness_white_ink_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.red    = 8'($urandom_range(0, 255));
        p.green  = 8'($urandom_range(0, 255));
        p.blue   = 8'($urandom_range(0, 255));
        p.opaque = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 9))
            0:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            1:
            begin
                p.red   = p.red & 8'h0F;
                p.green = p.green & 8'h0F;
                p.blue  = p.blue & 8'h0F;
            end
            2:
            begin
                p.red   = p.red | 8'hF0;
                p.green = p.green | 8'hF0;
                p.blue  = p.blue | 8'hF0;
            end
            3:
            begin
                p.red  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] sel_mode, input logic [7:0] thr);
        logic [31:0] data;
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        data = $urandom;
        data[1:0] = sel_mode;
        apb_write(REG_MODE, data);
        data = $urandom;
        data[7:0] = thr;
        apb_write(REG_THRESHOLD, data);
    endtask

    task automatic send_directed();
        send_pixel({8'd0, 8'd0, 8'd0, 1'b1});
        send_pixel({8'd255, 8'd255, 8'd255, 1'b1});
        send_pixel({8'd255, 8'd0, 8'd0, 1'b1});
        send_pixel({8'd0, 8'd255, 8'd0, 1'b1});
        send_pixel({8'd0, 8'd0, 8'd255, 1'b0});
        send_pixel({8'd128, 8'd128, 8'd128, 1'b1});
    endtask

    initial
    begin
        logic [1:0] sel_mode;
        logic [7:0] thr;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        result_ready = 1'b0;
        no_idle      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default config first, then every mode with edge thresholds
        send_directed();
        set_config(MODE_DARK_NEUTRAL, 8'd255);
        send_directed();
        set_config(MODE_MAX_CHANNEL, 8'd1);
        send_directed();
        set_config(MODE_UNUSED, 8'd0);
        send_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            sel_mode = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
            case (phase % 5)
                0: thr = 8'd1;
                1: thr = 8'd255;
                2: thr = 8'd0;
                default: thr = 8'($urandom_range(1, 255));
            endcase
            set_config(sel_mode, thr);
            no_idle = (phase % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_pixel(random_pixel());
            end
        end

        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
                || (psel && penable && pready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

endmodule
